@@ rtl/core/dpea_pkg.sv @@
package dpea_pkg;

    localparam int DATA_W = 32;
    localparam int FPS_W  = 10;
    localparam int PROD_W = DATA_W + FPS_W;
    localparam int DIV_W  = PROD_W + 2;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int ADDR_W = 3;

    localparam logic [FPS_W-1:0] FPS_SCALE      = 10'd1000;
    localparam logic [FPS_W-1:0] PERIOD_RESET   = 10'd33;
    localparam logic [ADDR_W-1:0] ADDR_PERIOD   = 3'd0;

    localparam logic [2:0] MODE_RESTART      = 3'd0;
    localparam logic [2:0] MODE_REFR_START   = 3'd1;
    localparam logic [2:0] MODE_REFR_READY   = 3'd2;
    localparam logic [2:0] MODE_RENDER_START = 3'd3;
    localparam logic [2:0] MODE_RENDER_READY = 3'd4;
    localparam logic [2:0] MODE_FLUSH_START  = 3'd5;
    localparam logic [2:0] MODE_FLUSH_FINISH = 3'd6;
    localparam logic [2:0] MODE_REPORT       = 3'd7;

    // Request to the shared divider; dividend is left-aligned, count is bits to develop.
    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  count;
        logic [DIV_W-1:0]  dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

endpackage

@@ rtl/core/dpea_if.sv @@
interface dpea_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] now_tick;

    modport source (output valid, mode, now_tick, input ready);
    modport sink   (input valid, mode, now_tick, output ready);
endinterface

interface dpea_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] duration_ms;
    logic [9:0]  frames_per_second;
    logic [31:0] refresh_avg_ms;
    logic [31:0] render_avg_ms;
    logic [31:0] flush_avg_ms;
    logic [9:0]  fps_running_avg;
    logic [31:0] refresh_count_out;
    logic [31:0] refresh_interval_total;

    modport source (output valid, duration_ms, frames_per_second, refresh_avg_ms,
                    render_avg_ms, flush_avg_ms, fps_running_avg, refresh_count_out,
                    refresh_interval_total, input ready);
    modport sink   (input valid, duration_ms, frames_per_second, refresh_avg_ms,
                    render_avg_ms, flush_avg_ms, fps_running_avg, refresh_count_out,
                    refresh_interval_total, output ready);
endinterface

@@ rtl/core/dpea_div.sv @@
module dpea_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dpea_pkg::t_div_req               i_req,
    output logic                             o_done,
    output logic [dpea_pkg::DIV_W-1:0]       o_quotient
);

    localparam int DIV_W  = dpea_pkg::DIV_W;
    localparam int DATA_W = dpea_pkg::DATA_W;
    localparam int CNT_W  = dpea_pkg::CNT_W;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W-1:0]   r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [DATA_W-1:0]   r_divisor;

    logic [DATA_W:0]     w_trial;
    logic [DATA_W+1:0]   w_diff;
    logic                w_ge;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_divisor};
    assign w_ge    = ~w_diff[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= i_req.count;
                r_rem     <= '0;
                r_quo     <= i_req.dividend;
                r_divisor <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/core/display_perf_event_accumulator.sv @@
// Display performance event accumulator.
//
// Event words arrive on i_evt (mode, now_tick) under valid/ready; report words
// leave on o_res. Restart, refresh, render and flush events update the marks,
// sums and counts in the cycle they are accepted, and the block is ready again
// in the next cycle.
// A report event starts a sequence on one shared restoring divider, one
// quotient bit per cycle: fps cap (10 bits), fps (42), refresh, render and
// flush averages (32 each) and the running fps mean (43). A 10x32 multiplier
// forms the two wide dividends first. The divisions run one after another, and
// a division whose divisor is zero is skipped and yields zero. The event port
// is not ready from acceptance of the report until the sequencer is idle again.
// The result sits in an output register: further events are taken while it
// waits, and a finished report holds in the sequencer until the receiver
// takes the previous word.
// refresh_period_ms lies at APB byte address 0; write it only while idle.
// Synchronous reset clears all statistics and sets the period to 33 ms.
module display_perf_event_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dpea_evt_if.sink                       i_evt,
    dpea_res_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpea_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int DATA_W = dpea_pkg::DATA_W;
    localparam int FPS_W  = dpea_pkg::FPS_W;
    localparam int PROD_W = dpea_pkg::PROD_W;
    localparam int DIV_W  = dpea_pkg::DIV_W;
    localparam int CNT_W  = dpea_pkg::CNT_W;

    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(FPS_W);
    localparam logic [CNT_W-1:0] CNT_FPS  = CNT_W'(PROD_W);
    localparam logic [CNT_W-1:0] CNT_AVG  = CNT_W'(DATA_W);
    localparam logic [CNT_W-1:0] CNT_MEAN = CNT_W'(PROD_W + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_FPS, S_MUL_AVG, S_LAUNCH, S_WAIT, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_CAP, OP_FPS, OP_REFR, OP_REND, OP_FLUSH, OP_MEAN
    } t_op;

    t_state r_state;
    t_op    r_op;

    // Configuration
    logic [FPS_W-1:0]  r_period;

    // Marks, sums and counts
    logic [DATA_W-1:0] r_global_refresh_mark, r_global_render_mark;
    logic [DATA_W-1:0] r_session_start, r_refresh_mark, r_render_mark;
    logic [DATA_W-1:0] r_flush_in_mark, r_flush_out_mark;
    logic              r_rendering;
    logic [DATA_W-1:0] r_interval_sum, r_refresh_sum, r_render_sum;
    logic [DATA_W-1:0] r_flush_in_sum, r_flush_out_sum;
    logic [DATA_W-1:0] r_refresh_count, r_render_count, r_report_count;
    logic [FPS_W-1:0]  r_fps_average;

    // Report working registers
    logic [DATA_W-1:0] r_dur;
    logic [PROD_W-1:0] r_prod_fps, r_prod_avg;
    logic [FPS_W-1:0]  r_cap, r_fps;
    logic [DATA_W-1:0] r_refr_avg, r_rend_avg, r_flush_avg;

    // Output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_dur, r_out_refr_avg, r_out_rend_avg, r_out_flush_avg;
    logic [DATA_W-1:0] r_out_refresh_count, r_out_interval;
    logic [FPS_W-1:0]  r_out_fps, r_out_fps_avg;

    logic              w_evt_accept;
    logic              w_cfg_write;
    logic [FPS_W-1:0]  w_mul_a;
    logic [DATA_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [DATA_W-1:0] w_net;
    logic [DATA_W-1:0] w_flush_total;
    logic [PROD_W:0]   w_mean_num;
    dpea_pkg::t_div_req w_req;
    logic              w_skip;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quotient;
    logic [DIV_W-1:0]  w_result;
    logic [DATA_W-1:0] n_report_count;

    dpea_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_evt_accept = i_evt.valid && i_evt.ready;
    assign i_evt.ready  = (r_state == S_IDLE);

    // APB: single register, zero-wait
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && (paddr == dpea_pkg::ADDR_PERIOD);
    assign prdata      = (paddr == dpea_pkg::ADDR_PERIOD) ? {{(32-FPS_W){1'b0}}, r_period}
                                                          : 32'd0;

    // Shared multiplier: 1000 * refresh_count, then fps_average * (reports - 1)
    assign w_mul_a = (r_state == S_MUL_FPS) ? dpea_pkg::FPS_SCALE : r_fps_average;
    assign w_mul_b = (r_state == S_MUL_FPS) ? r_refresh_count : (r_report_count - 1'b1);
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    assign w_net         = (r_render_sum > r_flush_in_sum) ? (r_render_sum - r_flush_in_sum)
                                                           : '0;
    assign w_flush_total = r_flush_in_sum + r_flush_out_sum;
    assign w_mean_num    = {1'b0, r_prod_avg} + (PROD_W + 1)'(r_fps);

    assign n_report_count = (r_report_count == '1) ? r_report_count : r_report_count + 1'b1;

    // Operand select for the current division
    always_comb begin
        w_req.count    = CNT_AVG;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        w_skip         = 1'b0;
        unique case (r_op)
            OP_CAP: begin
                w_req.count    = CNT_CAP;
                w_req.dividend = {dpea_pkg::FPS_SCALE, {(DIV_W-FPS_W){1'b0}}};
                w_req.divisor  = (r_period == '0) ? DATA_W'(1) : DATA_W'(r_period);
            end
            OP_FPS: begin
                w_req.count    = CNT_FPS;
                w_req.dividend = {r_prod_fps, {(DIV_W-PROD_W){1'b0}}};
                w_req.divisor  = r_dur;
                w_skip         = (r_dur == '0);
            end
            OP_REFR: begin
                w_req.dividend = {r_refresh_sum, {(DIV_W-DATA_W){1'b0}}};
                w_req.divisor  = r_refresh_count;
                w_skip         = (r_refresh_count == '0);
            end
            OP_REND: begin
                w_req.dividend = {w_net, {(DIV_W-DATA_W){1'b0}}};
                w_req.divisor  = r_render_count;
                w_skip         = (r_render_count == '0);
            end
            OP_FLUSH: begin
                w_req.dividend = {w_flush_total, {(DIV_W-DATA_W){1'b0}}};
                w_req.divisor  = r_render_count;
                w_skip         = (r_render_count == '0);
            end
            OP_MEAN: begin
                w_req.count    = CNT_MEAN;
                w_req.dividend = {w_mean_num, {(DIV_W-PROD_W-1){1'b0}}};
                w_req.divisor  = r_report_count;
            end
            default: begin
                w_skip = 1'b1;
            end
        endcase
        w_req.start = (r_state == S_LAUNCH) && !w_skip;
    end

    // A skipped division yields zero
    assign w_result = (r_state == S_LAUNCH) ? '0 : w_quotient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state               <= S_IDLE;
            r_op                  <= OP_CAP;
            r_period              <= dpea_pkg::PERIOD_RESET;
            r_global_refresh_mark <= '0;
            r_global_render_mark  <= '0;
            r_session_start       <= '0;
            r_refresh_mark        <= '0;
            r_render_mark         <= '0;
            r_flush_in_mark       <= '0;
            r_flush_out_mark      <= '0;
            r_rendering           <= 1'b0;
            r_interval_sum        <= '0;
            r_refresh_sum         <= '0;
            r_render_sum          <= '0;
            r_flush_in_sum        <= '0;
            r_flush_out_sum       <= '0;
            r_refresh_count       <= '0;
            r_render_count        <= '0;
            r_report_count        <= '0;
            r_fps_average         <= '0;
            r_out_valid           <= 1'b0;
        end else begin
            if (w_cfg_write) begin
                r_period <= pwdata[FPS_W-1:0];
            end
            // Drop the result word once the receiver takes it; S_OUT refills it itself
            if (o_res.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_evt_accept) begin
                        unique case (i_evt.mode)
                            dpea_pkg::MODE_RESTART: begin
                                r_session_start  <= i_evt.now_tick;
                                r_refresh_mark   <= r_global_refresh_mark;
                                r_render_mark    <= '0;
                                r_flush_in_mark  <= '0;
                                r_flush_out_mark <= '0;
                                r_rendering      <= 1'b0;
                                r_interval_sum   <= '0;
                                r_refresh_sum    <= '0;
                                r_render_sum     <= '0;
                                r_flush_in_sum   <= '0;
                                r_flush_out_sum  <= '0;
                                r_refresh_count  <= '0;
                                r_render_count   <= '0;
                            end
                            dpea_pkg::MODE_REFR_START: begin
                                r_global_refresh_mark <= i_evt.now_tick;
                                r_interval_sum <= r_interval_sum
                                                + (i_evt.now_tick - r_refresh_mark);
                                r_refresh_mark <= i_evt.now_tick;
                            end
                            dpea_pkg::MODE_REFR_READY: begin
                                r_global_refresh_mark <= '0;
                                r_refresh_sum   <= r_refresh_sum
                                                 + (i_evt.now_tick - r_refresh_mark);
                                r_refresh_count <= r_refresh_count + 1'b1;
                            end
                            dpea_pkg::MODE_RENDER_START: begin
                                r_global_render_mark <= i_evt.now_tick;
                                r_rendering          <= 1'b1;
                                r_render_mark        <= i_evt.now_tick;
                            end
                            dpea_pkg::MODE_RENDER_READY: begin
                                r_global_render_mark <= '0;
                                r_rendering    <= 1'b0;
                                r_render_sum   <= r_render_sum
                                                + (i_evt.now_tick - r_render_mark);
                                r_render_count <= r_render_count + 1'b1;
                            end
                            dpea_pkg::MODE_FLUSH_START: begin
                                if (r_rendering) begin
                                    r_flush_in_mark <= i_evt.now_tick;
                                end else begin
                                    r_flush_out_mark <= i_evt.now_tick;
                                end
                            end
                            dpea_pkg::MODE_FLUSH_FINISH: begin
                                if (r_rendering) begin
                                    r_flush_in_sum <= r_flush_in_sum
                                                    + (i_evt.now_tick - r_flush_in_mark);
                                end else begin
                                    r_flush_out_sum <= r_flush_out_sum
                                                     + (i_evt.now_tick - r_flush_out_mark);
                                end
                            end
                            dpea_pkg::MODE_REPORT: begin
                                r_dur          <= i_evt.now_tick - r_session_start;
                                r_report_count <= n_report_count;
                                r_state        <= S_MUL_FPS;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL_FPS: begin
                    r_prod_fps <= w_prod;
                    r_state    <= S_MUL_AVG;
                end
                S_MUL_AVG: begin
                    r_prod_avg <= w_prod;
                    r_op       <= OP_CAP;
                    r_state    <= S_LAUNCH;
                end
                S_LAUNCH, S_WAIT: begin
                    // Store on completion; a skipped division completes at launch
                    if ((r_state == S_LAUNCH && w_skip) || (r_state == S_WAIT && w_div_done))
                    begin
                        unique case (r_op)
                            OP_CAP:   r_cap <= w_result[FPS_W-1:0];
                            OP_FPS:   r_fps <= (w_result > DIV_W'(r_cap)) ? r_cap
                                                                        : w_result[FPS_W-1:0];
                            OP_REFR:  r_refr_avg  <= w_result[DATA_W-1:0];
                            OP_REND:  r_rend_avg  <= w_result[DATA_W-1:0];
                            OP_FLUSH: r_flush_avg <= w_result[DATA_W-1:0];
                            OP_MEAN:  r_fps_average <= w_result[FPS_W-1:0];
                            default: begin
                            end
                        endcase
                        if (r_op == OP_MEAN) begin
                            r_state <= S_OUT;
                        end else begin
                            r_op    <= t_op'(r_op + 3'd1);
                            r_state <= S_LAUNCH;
                        end
                    end else if (r_state == S_LAUNCH) begin
                        r_state <= S_WAIT;
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid         <= 1'b1;
                        r_out_dur           <= r_dur;
                        r_out_fps           <= r_fps;
                        r_out_refr_avg      <= r_refr_avg;
                        r_out_rend_avg      <= r_rend_avg;
                        r_out_flush_avg     <= r_flush_avg;
                        r_out_fps_avg       <= r_fps_average;
                        r_out_refresh_count <= r_refresh_count;
                        r_out_interval      <= r_interval_sum;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid                  = r_out_valid;
    assign o_res.duration_ms            = r_out_dur;
    assign o_res.frames_per_second      = r_out_fps;
    assign o_res.refresh_avg_ms         = r_out_refr_avg;
    assign o_res.render_avg_ms          = r_out_rend_avg;
    assign o_res.flush_avg_ms           = r_out_flush_avg;
    assign o_res.fps_running_avg        = r_out_fps_avg;
    assign o_res.refresh_count_out      = r_out_refresh_count;
    assign o_res.refresh_interval_total = r_out_interval;

endmodule

@@ tb/display_perf_event_accumulator_test.sv @@
`timescale 1ns / 1ps

module display_perf_event_accumulator_test;

    // Timeout: every word a report, each report a full divider sequence plus output stalls, several times over.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // Settle past the run of one report on the serial divider.
    localparam int unsigned SETTLE_CYCLES = 256;
    // Long receiver hold-off so the output register and the sequencer both fill.
    localparam int unsigned HOLD_CYCLES = 1500;

    logic i_clk;
    logic i_rst_n;

    dpea_evt_if evt ();
    dpea_res_if res ();

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dpea_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    display_perf_event_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // One report word as the block presents it.
    typedef struct packed {
        logic [31:0] duration_ms;
        logic [9:0]  fps;
        logic [31:0] refresh_avg;
        logic [31:0] render_avg;
        logic [31:0] flush_avg;
        logic [9:0]  fps_avg;
        logic [31:0] refresh_count;
        logic [31:0] interval_total;
    } t_report;

    t_report pending_reports[$];

    // Statistics state of the predictor, mirroring what the block keeps.
    logic [9:0]  period_ms;
    logic [31:0] glob_refresh_mark;
    logic [31:0] glob_render_mark;
    logic [31:0] session_tick;
    logic [31:0] refresh_from;
    logic [31:0] render_from;
    logic [31:0] flush_in_from;
    logic [31:0] flush_out_from;
    logic        in_render;
    logic [31:0] interval_acc;
    logic [31:0] refresh_acc;
    logic [31:0] render_acc;
    logic [31:0] flush_in_acc;
    logic [31:0] flush_out_acc;
    logic [31:0] refreshes;
    logic [31:0] renders;
    logic [31:0] reports_seen;
    logic [9:0]  fps_mean;

    int unsigned fail_count      = 0;
    int unsigned reports_checked = 0;
    int unsigned events_sent     = 0;
    int unsigned cycle_count     = 0;

    // Sender and receiver idling controls.
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    int unsigned hold_trigger = 0;

    // Random traffic timeline.
    logic [31:0] tick_now;
    int unsigned tick_step;

    //--------------------------------------------------------------------------
    // Clock, timeout
    //--------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d reports still expected",
                 cycle_count, pending_reports.size());
        $display("== FAIL ==");
        $finish;
    end

    //--------------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------------

    // Start a fresh session; the refresh mark picks up any refresh in flight.
    function automatic void clear_session(input logic [31:0] tick);
        session_tick   = tick;
        refresh_from   = glob_refresh_mark;
        render_from    = '0;
        flush_in_from  = '0;
        flush_out_from = '0;
        in_render      = 1'b0;
        interval_acc   = '0;
        refresh_acc    = '0;
        render_acc     = '0;
        flush_in_acc   = '0;
        flush_out_acc  = '0;
        refreshes      = '0;
        renders        = '0;
    endfunction

    function automatic void reset_statistics();
        period_ms         = dpea_pkg::PERIOD_RESET;
        glob_refresh_mark = '0;
        glob_render_mark  = '0;
        clear_session('0);
        reports_seen      = '0;
        fps_mean          = '0;
    endfunction

    // Apply one accepted event word; a report queues the expected result word.
    function automatic void account_event(input logic [2:0] mode, input logic [31:0] tick);
        t_report     r;
        logic [31:0] duration;
        logic [31:0] period;
        logic [31:0] cap;
        logic [31:0] net_render;
        logic [31:0] flush_total;
        logic [31:0] prior_reports;
        logic [63:0] fps;
        logic [63:0] acc;
        case (mode)
            dpea_pkg::MODE_RESTART: begin
                clear_session(tick);
            end
            dpea_pkg::MODE_REFR_START: begin
                glob_refresh_mark = tick;
                interval_acc      = interval_acc + (tick - refresh_from);
                refresh_from      = tick;
            end
            dpea_pkg::MODE_REFR_READY: begin
                glob_refresh_mark = '0;
                refresh_acc       = refresh_acc + (tick - refresh_from);
                refreshes         = refreshes + 32'd1;
            end
            dpea_pkg::MODE_RENDER_START: begin
                glob_render_mark = tick;
                in_render        = 1'b1;
                render_from      = tick;
            end
            dpea_pkg::MODE_RENDER_READY: begin
                glob_render_mark = '0;
                in_render        = 1'b0;
                render_acc       = render_acc + (tick - render_from);
                renders          = renders + 32'd1;
            end
            dpea_pkg::MODE_FLUSH_START: begin
                if (in_render) flush_in_from = tick;
                else flush_out_from = tick;
            end
            dpea_pkg::MODE_FLUSH_FINISH: begin
                // An unmatched finish measures from whatever mark is held.
                if (in_render) flush_in_acc = flush_in_acc + (tick - flush_in_from);
                else flush_out_acc = flush_out_acc + (tick - flush_out_from);
            end
            dpea_pkg::MODE_REPORT: begin
                r        = '0;
                duration = tick - session_tick;
                // A zero period caps like a 1 ms period.
                period   = (period_ms == '0) ? 32'd1 : {22'd0, period_ms};
                cap      = {22'd0, dpea_pkg::FPS_SCALE} / period;
                fps      = '0;
                // Form the scaled refresh count at full width, no wrap.
                if (duration != '0)
                    fps = (64'(dpea_pkg::FPS_SCALE) * {32'd0, refreshes}) / duration;
                if (fps > {32'd0, cap}) fps = {32'd0, cap};
                if (refreshes != '0) r.refresh_avg = refresh_acc / refreshes;
                if (renders != '0) begin
                    // Render time net of in-render flushing clamps at zero.
                    net_render   = (render_acc > flush_in_acc) ? render_acc - flush_in_acc : '0;
                    flush_total  = flush_in_acc + flush_out_acc;
                    r.render_avg = net_render / renders;
                    r.flush_avg  = flush_total / renders;
                end
                // Saturate the report count.
                if (reports_seen != '1) reports_seen = reports_seen + 32'd1;
                prior_reports    = reports_seen - 32'd1;
                acc              = {54'd0, fps_mean} * {32'd0, prior_reports} + fps;
                fps_mean         = 10'(acc / {32'd0, reports_seen});
                r.duration_ms    = duration;
                r.fps            = fps[9:0];
                r.fps_avg        = fps_mean;
                r.refresh_count  = refreshes;
                r.interval_total = interval_acc;
                pending_reports.push_back(r);
            end
            default: ;
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // Result side: receiver stalls and the report checker
    //--------------------------------------------------------------------------
    initial begin : receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_reports
        t_report want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_reports.size() == 0) begin
                $error("report word with no report expected");
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("duration_ms", want.duration_ms, res.duration_ms);
                check_field("frames_per_second", {22'd0, want.fps},
                            {22'd0, res.frames_per_second});
                check_field("refresh_avg_ms", want.refresh_avg, res.refresh_avg_ms);
                check_field("render_avg_ms", want.render_avg, res.render_avg_ms);
                check_field("flush_avg_ms", want.flush_avg, res.flush_avg_ms);
                check_field("fps_running_avg", {22'd0, want.fps_avg},
                            {22'd0, res.fps_running_avg});
                check_field("refresh_count_out", want.refresh_count, res.refresh_count_out);
                check_field("refresh_interval_total", want.interval_total,
                            res.refresh_interval_total);
                reports_checked++;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Event side
    //--------------------------------------------------------------------------

    // Offer one event word, idling first at the current rate, and hold it until taken.
    task automatic send_event(input logic [2:0] mode, input logic [31:0] tick);
        while ($urandom_range(99) < idle_pct) begin
            evt.valid    <= 1'b0;
            evt.mode     <= 3'($urandom());
            evt.now_tick <= $urandom();
            @(posedge i_clk);
        end
        evt.valid    <= 1'b1;
        evt.mode     <= mode;
        evt.now_tick <= tick;
        @(posedge i_clk);
        while (!evt.ready) @(posedge i_clk);
        account_event(mode, tick);
        events_sent++;
    endtask

    // Advance the timeline by a random step and send the event there.
    task automatic send_next(input logic [2:0] mode);
        tick_now = tick_now + $urandom_range(tick_step, 0);
        send_event(mode, tick_now);
    endtask

    // Drop valid, wait out every expected report, then let the sequencer settle.
    task automatic drain_reports();
        evt.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the refresh period: setup, then access until pready.
    task automatic program_period(input logic [9:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dpea_pkg::ADDR_PERIOD;
        pwdata  <= {22'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        period_ms = value;
    endtask

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    // Report straight out of reset: zero duration, zero counts, all zeros.
    task automatic test_report_after_reset();
        send_event(dpea_pkg::MODE_REPORT, 32'd0);
    endtask

    // Session across the tick wrap; a backward in-render flush forces the render clamp.
    task automatic test_tick_wrap();
        send_event(dpea_pkg::MODE_RESTART,      32'hFFFF_FFF0);
        send_event(dpea_pkg::MODE_REFR_START,   32'hFFFF_FFF8);
        send_event(dpea_pkg::MODE_REFR_READY,   32'h0000_0004);
        send_event(dpea_pkg::MODE_RENDER_START, 32'h0000_0005);
        send_event(dpea_pkg::MODE_FLUSH_START,  32'h0000_0006);
        send_event(dpea_pkg::MODE_FLUSH_FINISH, 32'h0000_0002);
        send_event(dpea_pkg::MODE_RENDER_READY, 32'h0000_0009);
        send_event(dpea_pkg::MODE_FLUSH_START,  32'h0000_000A);
        send_event(dpea_pkg::MODE_FLUSH_FINISH, 32'hFFFF_FFFF);
        send_event(dpea_pkg::MODE_REPORT,       32'hFFFF_FFFF);
    endtask

    // Restart inherits a refresh in flight; ready clears it; unmatched flush finish;
    // reports at zero and one tick of duration.
    task automatic test_stale_marks();
        send_event(dpea_pkg::MODE_REFR_START,   32'h8000_0000);
        send_event(dpea_pkg::MODE_RESTART,      32'h8000_0010);
        send_event(dpea_pkg::MODE_REFR_READY,   32'h8000_0020);
        send_event(dpea_pkg::MODE_FLUSH_FINISH, 32'h8000_0030);
        send_event(dpea_pkg::MODE_RESTART,      32'h8000_0040);
        send_event(dpea_pkg::MODE_REPORT,       32'h8000_0040);
        send_event(dpea_pkg::MODE_REPORT,       32'h8000_0041);
    endtask

    // Two refreshes in two ticks: raw fps far above the period cap.
    task automatic test_fps_cap();
        send_event(dpea_pkg::MODE_RESTART,    32'd100);
        send_event(dpea_pkg::MODE_REFR_START, 32'd100);
        send_event(dpea_pkg::MODE_REFR_READY, 32'd100);
        send_event(dpea_pkg::MODE_REFR_START, 32'd101);
        send_event(dpea_pkg::MODE_REFR_READY, 32'd101);
        send_event(dpea_pkg::MODE_REPORT,     32'd102);
    endtask

    // Hold the receiver off while reports keep coming, so the event port stalls.
    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    <= 0;
        hold_trigger <= hold_trigger + 1;
        tick_now     = 32'd5000;
        tick_step    = 3;
        send_next(dpea_pkg::MODE_RESTART);
        repeat (12) begin
            send_next(dpea_pkg::MODE_REFR_START);
            send_next(dpea_pkg::MODE_REFR_READY);
            send_next(dpea_pkg::MODE_REPORT);
        end
        drain_reports();
    endtask

    // Well-formed frames with random content, plus restarts, broken frames and noise.
    task automatic test_random_traffic(input logic [9:0] period, input int unsigned sender_idle,
                                       input int unsigned recv_stall, input int unsigned count);
        int unsigned first;
        int unsigned pick;
        program_period(period);
        idle_pct  = sender_idle;
        stall_pct <= recv_stall;
        first     = events_sent;
        tick_now  = $urandom();
        tick_step = 20;
        send_next(dpea_pkg::MODE_RESTART);
        while (events_sent - first < count) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                // Noise: any mode at any tick.
                send_event(3'($urandom()), $urandom());
            end else if (pick < 20) begin
                // New session, sometimes just below the wrap point.
                case ($urandom_range(2))
                    0: tick_now = $urandom();
                    1: tick_now = 32'hFFFF_FFFF - $urandom_range(400);
                    default: ;
                endcase
                case ($urandom_range(3))
                    0: tick_step = 1;
                    1: tick_step = 4;
                    2: tick_step = 20;
                    default: tick_step = 80;
                endcase
                send_next(dpea_pkg::MODE_RESTART);
            end else begin
                // One frame; occasionally a start or ready goes missing.
                if ($urandom_range(9) != 0) send_next(dpea_pkg::MODE_REFR_START);
                if ($urandom_range(1) == 0) begin
                    send_next(dpea_pkg::MODE_RENDER_START);
                    if ($urandom_range(1) == 0) begin
                        send_next(dpea_pkg::MODE_FLUSH_START);
                        send_next(dpea_pkg::MODE_FLUSH_FINISH);
                    end
                    if ($urandom_range(9) != 0) send_next(dpea_pkg::MODE_RENDER_READY);
                end
                if ($urandom_range(2) == 0) begin
                    send_next(dpea_pkg::MODE_FLUSH_START);
                    send_next(dpea_pkg::MODE_FLUSH_FINISH);
                end
                send_next(dpea_pkg::MODE_REFR_READY);
                if ($urandom_range(2) == 0) send_next(dpea_pkg::MODE_REPORT);
            end
        end
        drain_reports();
    endtask

    //--------------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------------
    initial begin
        reset_statistics();
        i_rst_n      <= 1'b0;
        evt.valid    <= 1'b0;
        evt.mode     <= dpea_pkg::MODE_RESTART;
        evt.now_tick <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= dpea_pkg::ADDR_PERIOD;
        pwdata       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words run at the reset period, no idling.
        test_report_after_reset();
        test_tick_wrap();
        test_stale_marks();
        test_fps_cap();
        drain_reports();

        test_random_traffic(10'd1,    0,  0,  265);
        test_random_traffic(10'd1000, 51, 0,  265);
        test_random_traffic(10'd0,    0,  51, 265);
        test_random_traffic(10'd1023, 13, 13, 265);
        test_random_traffic(10'($urandom_range(1000, 1)), 0, 0, 230);
        program_period(dpea_pkg::PERIOD_RESET);
        test_backpressure();

        drain_reports();
        $display("%0d event words sent, %0d report words checked", events_sent, reports_checked);
        $display("periods 33/1/1000/0/1023/random, tick wrap, stale marks, fps cap, long stall");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/dpea_pkg.sv
rtl/core/dpea_if.sv
rtl/core/dpea_div.sv
rtl/core/display_perf_event_accumulator.sv
tb/display_perf_event_accumulator_test.sv
